// File: hdl/swhk_pkg.sv
package swhk_pkg;

    localparam int CORDIC_STAGES_DEF = 20;

    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    typedef enum logic [1:0] {
        REG_PIVOT_LENGTH,
        REG_AZIMUTH_OFFSET,
        REG_TILT_NEGATE
    } cfg_reg_t;

    localparam logic [30:0]        PIVOT_LENGTH_RST   = 31'd16384000;
    localparam logic signed [31:0] AZIMUTH_OFFSET_RST = 32'sd5898240;
    localparam logic               TILT_NEGATE_RST    = 1'b0;

    localparam logic signed [33:0] DEG_HALF  = 34'sd11796480;
    localparam logic signed [18:0] MOD_BIAS  = 19'sd131400;
    localparam logic [17:0]        MOD_RECIP = 18'd186413;
    localparam int                 MOD_SHIFT = 26;
    localparam logic [9:0]         DEG_FULL  = 10'd360;
    localparam logic [26:0]        DIV_RECIP = 27'd95443717;
    localparam logic [7:0]         TURN_MUL  = 8'd182;
    localparam logic [6:0]         TURN_DIV  = 7'd45;

    localparam logic signed [32:0] INV_GAIN = 33'sd652032874;
    localparam logic signed [33:0] QUARTER  = 34'sd1073741824;
    localparam logic signed [33:0] HALF     = 34'sd2147483648;

    typedef struct packed {
        logic               operation;
        logic signed [31:0] lin_x;
        logic signed [31:0] lin_y;
        logic signed [31:0] lin_z;
        logic signed [31:0] angle_a;
        logic signed [31:0] angle_c;
    } req_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [31:0] out_a;
        logic signed [31:0] out_c;
        logic               overflow;
    } rsp_t;

    typedef struct packed {
        logic signed [32:0] x;
        logic signed [32:0] y;
        logic signed [33:0] z;
        logic               neg;
    } vec_t;

    typedef struct packed {
        vec_t th;
        vec_t ph;
        req_t pl;
    } cell_data_t;

    function automatic logic signed [33:0] atan_turns(input logic [4:0] idx);
        logic signed [33:0] a;
        case (idx)
            5'd0:    a = 34'sh20000000;
            5'd1:    a = 34'sh12E4051E;
            5'd2:    a = 34'sh09FB385B;
            5'd3:    a = 34'sh051111D4;
            5'd4:    a = 34'sh028B0D43;
            5'd5:    a = 34'sh0145D7E1;
            5'd6:    a = 34'sh00A2F61E;
            5'd7:    a = 34'sh00517C55;
            5'd8:    a = 34'sh0028BE53;
            5'd9:    a = 34'sh00145F2F;
            5'd10:   a = 34'sh000A2F98;
            5'd11:   a = 34'sh000517CC;
            5'd12:   a = 34'sh00028BE6;
            5'd13:   a = 34'sh000145F3;
            5'd14:   a = 34'sh0000A2FA;
            5'd15:   a = 34'sh0000517D;
            5'd16:   a = 34'sh000028BE;
            5'd17:   a = 34'sh0000145F;
            5'd18:   a = 34'sh00000A30;
            5'd19:   a = 34'sh00000518;
            5'd20:   a = 34'sh0000028C;
            5'd21:   a = 34'sh00000146;
            5'd22:   a = 34'sh000000A3;
            5'd23:   a = 34'sh00000051;
            5'd24:   a = 34'sh00000029;
            5'd25:   a = 34'sh00000014;
            5'd26:   a = 34'sh0000000A;
            5'd27:   a = 34'sh00000005;
            5'd28:   a = 34'sh00000003;
            5'd29:   a = 34'sh00000001;
            5'd30:   a = 34'sh00000001;
            default: a = 34'sh00000000;
        endcase
        return a;
    endfunction

    function automatic vec_t cordic_start(input logic [31:0] turns);
        logic signed [33:0] z;
        vec_t v;
        z = {{2{turns[31]}}, turns};
        v.neg = 1'b0;
        if (z > QUARTER)
        begin
            z = z - HALF;
            v.neg = 1'b1;
        end
        else if (z < -QUARTER)
        begin
            z = z + HALF;
            v.neg = 1'b1;
        end
        v.x = INV_GAIN;
        v.y = '0;
        v.z = z;
        return v;
    endfunction

    function automatic logic [32:0] sat32(input logic signed [39:0] v);
        logic [32:0] r;
        if (v > 40'sd2147483647)
            r = {1'b1, 32'h7FFF_FFFF};
        else if (v < -40'sd2147483648)
            r = {1'b1, 32'h8000_0000};
        else
            r = {1'b0, v[31:0]};
        return r;
    endfunction

endpackage

// File: hdl/swhk_if.sv
interface swhk_req_if import swhk_pkg::*; ();
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface swhk_rsp_if import swhk_pkg::*; ();
    logic valid;
    logic ready;
    rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hdl/swhk_turns.sv
module swhk_turns import swhk_pkg::*; (
    input  logic               clk,
    input  logic [3:0]         load,
    input  logic signed [33:0] deg,
    output logic [31:0]        turns
);

    logic signed [17:0] hi;
    logic [18:0]        u_next;
    logic [36:0]        uq_prod;
    logic [9:0]         q_next;
    logic [18:0]        u_reg;
    logic [15:0]        lo_reg;
    logic [9:0]         q_reg;

    logic [19:0]        rr;
    logic [8:0]         rr_fix;
    logic [24:0]        r_reg;

    logic [25:0]        t_next;
    logic [52:0]        tq_prod;
    logic [20:0]        qq_next;
    logic [31:0]        p_next;
    logic [25:0]        t_reg;
    logic [20:0]        qq_reg;
    logic [31:0]        p_reg;

    logic [26:0]        rem;
    logic [31:0]        turns_next;
    logic [31:0]        turns_reg;

    always_comb
    begin
        hi      = deg[33:16];
        u_next  = 19'({hi[17], hi} + MOD_BIAS);
        uq_prod = 37'(u_next) * 37'(MOD_RECIP);
        q_next  = 10'(uq_prod >> MOD_SHIFT);

        rr     = 20'(u_reg) - 20'(q_reg) * 20'(DEG_FULL);
        rr_fix = (rr >= 20'(DEG_FULL)) ? 9'(rr - 20'(DEG_FULL)) : 9'(rr);

        t_next  = {r_reg, 1'b0};
        tq_prod = 53'(t_next) * 53'(DIV_RECIP);
        qq_next = 21'(tq_prod >> 32);
        p_next  = 32'(r_reg) * 32'(TURN_MUL);

        rem        = 27'(t_reg) - 27'(qq_reg) * 27'(TURN_DIV);
        turns_next = p_reg + 32'(qq_reg) + 32'(rem >= 27'(TURN_DIV));
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            u_reg  <= u_next;
            lo_reg <= deg[15:0];
            q_reg  <= q_next;
        end
        if (load[1])
            r_reg <= {rr_fix, lo_reg};
        if (load[2])
        begin
            t_reg  <= t_next;
            qq_reg <= qq_next;
            p_reg  <= p_next;
        end
        if (load[3])
            turns_reg <= turns_next;
    end

    assign turns = turns_reg;

endmodule

// File: hdl/swhk_cordic_cell.sv
module swhk_cordic_cell import swhk_pkg::*; #(
    parameter int STAGE = 0
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       vin,
    input  cell_data_t din,
    input  logic       dn_take,
    output logic       up_take,
    output logic       vout,
    output cell_data_t dout
);

    localparam logic signed [33:0] ATAN = atan_turns(5'(STAGE));

    logic       v_reg;
    cell_data_t d_reg;
    cell_data_t d_next;

    function automatic vec_t rot(input vec_t v);
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        vec_t r;
        dx = v.y >>> STAGE;
        dy = v.x >>> STAGE;
        r  = v;
        if (!v.z[33])
        begin
            r.x = v.x - dx;
            r.y = v.y + dy;
            r.z = v.z - ATAN;
        end
        else
        begin
            r.x = v.x + dx;
            r.y = v.y - dy;
            r.z = v.z + ATAN;
        end
        return r;
    endfunction

    always_comb
    begin
        d_next    = din;
        d_next.th = rot(din.th);
        d_next.ph = rot(din.ph);
    end

    assign up_take = ~v_reg | dn_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (up_take)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (up_take)
            d_reg <= d_next;
    end

    assign vout = v_reg;
    assign dout = d_reg;

endmodule

// File: hdl/swivel_head_tool_tip_kinematics_unit.sv
// Tool-tip kinematics for an A/C swivel head, Q16.16 millimetres and degrees.
// Channels: req (sink) carries one transform request per transfer: operation
// (forward or inverse), X, Y, Z and the A and C angles. rsp (source) returns
// one result per request, in order: X, Y, Z (saturated), A and C unchanged,
// and an overflow flag. Both use valid/ready; a transfer happens when both
// are high at a rising clock edge.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 pivot
// length, 1 azimuth offset, 2 tilt sign); other indexes are ignored. Write
// only while no request is in flight.
// Pipeline: from request transfer to rsp.valid a request passes the angle
// reduction stages, CORDIC_STAGES CORDIC cells (default 20 stages), then
// the stages of products, sums and saturation.
// Throughput: one request per cycle until a held rsp fills the pipeline;
// every stage has its own valid bit and advances whenever the stage after
// it is empty or advancing. Stall: while rsp is held, results collect in
// empty stages and req.ready stays high until the pipeline is full.
// Reset: clears all stage valid bits and loads the register reset values.
module swivel_head_tool_tip_kinematics_unit import swhk_pkg::*; #(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    swhk_req_if.sink    req,
    swhk_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int NPRE  = 5;
    localparam int NPOST = 5;

    logic [30:0]        pivot_len_reg;
    logic signed [31:0] azimuth_reg;
    logic               tilt_neg_reg;

    logic [NPRE-1:0]    v_pre_reg;
    logic [NPRE:0]      tk_pre;
    req_t               pl_pre_reg [NPRE];
    logic signed [33:0] theta_reg;
    logic signed [33:0] phi_reg;
    logic signed [33:0] theta_next;
    logic signed [33:0] phi_next;
    logic signed [33:0] a_ext;
    logic [31:0]        th_turns;
    logic [31:0]        ph_turns;

    cell_data_t         chain_d [CORDIC_STAGES+1];
    logic [CORDIC_STAGES:0] chain_v;
    logic [CORDIC_STAGES:0] chain_tk;

    logic [NPOST-1:0]   v_post_reg;
    logic [NPOST:0]     tk_post;
    req_t               pl_post_reg [NPOST-1];

    logic signed [32:0] st_reg, ct_reg, sp_reg, cp_reg;
    logic signed [32:0] st1_reg, ct1_reg;
    logic signed [65:0] prod_s_reg, prod_c_reg;
    logic signed [32:0] st2_reg, ct2_reg;
    logic signed [33:0] lsp_reg, rz_reg;
    logic signed [33:0] rz3_reg;
    logic signed [66:0] px_reg, py_reg;
    rsp_t               out_reg;
    rsp_t               out_next;

    logic signed [39:0] rx, ry, rz40, len40;
    logic signed [39:0] sx, sy, sz;
    logic [32:0]        satx, saty, satz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pivot_len_reg <= PIVOT_LENGTH_RST;
            azimuth_reg   <= AZIMUTH_OFFSET_RST;
            tilt_neg_reg  <= TILT_NEGATE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_PIVOT_LENGTH:   pivot_len_reg <= cfg_data[30:0];
                REG_AZIMUTH_OFFSET: azimuth_reg   <= cfg_data;
                REG_TILT_NEGATE:    tilt_neg_reg  <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        tk_pre[NPRE] = chain_tk[0];
        for (int k = NPRE - 1; k >= 0; k--)
            tk_pre[k] = ~v_pre_reg[k] | tk_pre[k+1];
        tk_post[NPOST] = rsp.ready;
        for (int k = NPOST - 1; k >= 0; k--)
            tk_post[k] = ~v_post_reg[k] | tk_post[k+1];
    end

    assign req.ready = tk_pre[0];

    always_comb
    begin
        a_ext      = {{2{req.data.angle_a[31]}}, req.data.angle_a};
        theta_next = {{2{req.data.angle_c[31]}}, req.data.angle_c}
                   + {{2{azimuth_reg[31]}}, azimuth_reg};
        phi_next   = tilt_neg_reg ? (DEG_HALF + a_ext) : (DEG_HALF - a_ext);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_pre_reg <= '0;
        else
        begin
            if (tk_pre[0])
                v_pre_reg[0] <= req.valid;
            for (int k = 1; k < NPRE; k++)
                if (tk_pre[k])
                    v_pre_reg[k] <= v_pre_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (tk_pre[0])
        begin
            pl_pre_reg[0] <= req.data;
            theta_reg     <= theta_next;
            phi_reg       <= phi_next;
        end
        for (int k = 1; k < NPRE; k++)
            if (tk_pre[k])
                pl_pre_reg[k] <= pl_pre_reg[k-1];
    end

    swhk_turns u_turns_theta (
        .clk   (clk),
        .load  (tk_pre[NPRE-1:1]),
        .deg   (theta_reg),
        .turns (th_turns)
    );

    swhk_turns u_turns_phi (
        .clk   (clk),
        .load  (tk_pre[NPRE-1:1]),
        .deg   (phi_reg),
        .turns (ph_turns)
    );

    assign chain_d[0] = {cordic_start(th_turns), cordic_start(ph_turns),
                         pl_pre_reg[NPRE-1]};

    assign chain_v[0]              = v_pre_reg[NPRE-1];
    assign chain_tk[CORDIC_STAGES] = tk_post[0];

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_cell
        swhk_cordic_cell #(
            .STAGE (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .vin     (chain_v[i]),
            .din     (chain_d[i]),
            .dn_take (chain_tk[i+1]),
            .up_take (chain_tk[i]),
            .vout    (chain_v[i+1]),
            .dout    (chain_d[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_post_reg <= '0;
        else
        begin
            if (tk_post[0])
                v_post_reg[0] <= chain_v[CORDIC_STAGES];
            for (int k = 1; k < NPOST; k++)
                if (tk_post[k])
                    v_post_reg[k] <= v_post_reg[k-1];
        end
    end

    always_comb
    begin
        rx    = 40'((px_reg + 67'sd536870912) >>> 30);
        ry    = 40'((py_reg + 67'sd536870912) >>> 30);
        rz40  = 40'(rz3_reg);
        len40 = 40'({1'b0, pivot_len_reg});
        if (pl_post_reg[3].operation == OP_INVERSE)
        begin
            sx = 40'(pl_post_reg[3].lin_x) - rx;
            sy = 40'(pl_post_reg[3].lin_y) - ry;
            sz = 40'(pl_post_reg[3].lin_z) - len40 - rz40;
        end
        else
        begin
            sx = 40'(pl_post_reg[3].lin_x) + rx;
            sy = 40'(pl_post_reg[3].lin_y) + ry;
            sz = 40'(pl_post_reg[3].lin_z) + len40 + rz40;
        end
        satx = sat32(sx);
        saty = sat32(sy);
        satz = sat32(sz);
        out_next.out_x    = satx[31:0];
        out_next.out_y    = saty[31:0];
        out_next.out_z    = satz[31:0];
        out_next.out_a    = pl_post_reg[3].angle_a;
        out_next.out_c    = pl_post_reg[3].angle_c;
        out_next.overflow = satx[32] | saty[32] | satz[32];
    end

    always_ff @(posedge clk)
    begin
        if (tk_post[0])
        begin
            pl_post_reg[0] <= chain_d[CORDIC_STAGES].pl;
            st_reg <= chain_d[CORDIC_STAGES].th.neg ? -chain_d[CORDIC_STAGES].th.y
                                                    : chain_d[CORDIC_STAGES].th.y;
            ct_reg <= chain_d[CORDIC_STAGES].th.neg ? -chain_d[CORDIC_STAGES].th.x
                                                    : chain_d[CORDIC_STAGES].th.x;
            sp_reg <= chain_d[CORDIC_STAGES].ph.neg ? -chain_d[CORDIC_STAGES].ph.y
                                                    : chain_d[CORDIC_STAGES].ph.y;
            cp_reg <= chain_d[CORDIC_STAGES].ph.neg ? -chain_d[CORDIC_STAGES].ph.x
                                                    : chain_d[CORDIC_STAGES].ph.x;
        end
        if (tk_post[1])
        begin
            pl_post_reg[1] <= pl_post_reg[0];
            prod_s_reg     <= $signed({2'b00, pivot_len_reg}) * sp_reg;
            prod_c_reg     <= $signed({2'b00, pivot_len_reg}) * cp_reg;
            st1_reg        <= st_reg;
            ct1_reg        <= ct_reg;
        end
        if (tk_post[2])
        begin
            pl_post_reg[2] <= pl_post_reg[1];
            lsp_reg        <= 34'((prod_s_reg + 66'sd536870912) >>> 30);
            rz_reg         <= 34'((prod_c_reg + 66'sd536870912) >>> 30);
            st2_reg        <= st1_reg;
            ct2_reg        <= ct1_reg;
        end
        if (tk_post[3])
        begin
            pl_post_reg[3] <= pl_post_reg[2];
            px_reg         <= lsp_reg * ct2_reg;
            py_reg         <= lsp_reg * st2_reg;
            rz3_reg        <= rz_reg;
        end
        if (tk_post[4])
            out_reg <= out_next;
    end

    assign rsp.valid = v_post_reg[NPOST-1];
    assign rsp.data  = out_reg;

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> v_pre_reg[0])
        else $error("accepted request did not enter the first stage");

    a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.data.overflow) |->
            (rsp.data.out_x == 32'sh7FFF_FFFF || rsp.data.out_x == 32'sh8000_0000 ||
             rsp.data.out_y == 32'sh7FFF_FFFF || rsp.data.out_y == 32'sh8000_0000 ||
             rsp.data.out_z == 32'sh7FFF_FFFF || rsp.data.out_z == 32'sh8000_0000))
        else $error("overflow raised without a saturated coordinate");

    a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.ready && !v_post_reg[NPOST-2]) |=> !rsp.valid)
        else $error("result repeated after transfer");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |=> rsp.valid)
        else $error("stalled result dropped");

endmodule
